FILE: rtl/core/zrd_pkg.sv
// zrd_pkg: shared types, codes and sizes of the zero-run / delta decompressor
// used by zrd_ram, zrd_ctrl and zero_run_delta_decompressor_unit
package zrd_pkg;

  localparam int DEST_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(DEST_DEPTH);
  localparam int LEN_W      = 11;
  localparam int SRC_LEN_W  = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] FUNC_SOURCE  = 2'd0;
  localparam logic [1:0] FUNC_PRELOAD = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_LEN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_SIZE  = 2'd3;

  localparam logic RESULT_REPORT = 1'b0;
  localparam logic RESULT_READ   = 1'b1;

  typedef enum logic [1:0] {
    PH_LIT_COUNT,
    PH_LITERALS,
    PH_ZERO_COUNT
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_ZERO,
    ST_RDATA
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_value;
    logic [9:0] mem_address;
  } in_word_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       read_data;
    logic [LEN_W-1:0] out_length;
    logic             frame_error;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

FILE: rtl/core/zrd_ram.sv
// zrd_ram: destination byte store, one port, registered read data
// uses zrd_pkg for depth and the request struct
module zrd_ram (
  input  logic              clk,
  input  zrd_pkg::ram_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [zrd_pkg::DEST_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

FILE: rtl/core/zrd_ctrl.sv
// zrd_ctrl: configuration registers, frame decoder and memory sequencer
// uses zrd_pkg; drives zrd_ram through a request struct
module zrd_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [zrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [zrd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  zrd_pkg::in_word_t               in_data,
  output zrd_pkg::ram_req_t               ram_req,
  input  logic [7:0]                      ram_rdata,
  output zrd_pkg::out_word_t              pend,
  output logic                            pend_valid,
  input  logic                            pend_take
);

  localparam int LW = zrd_pkg::LEN_W;
  localparam int AW = zrd_pkg::ADDR_W;
  localparam int SW = zrd_pkg::SRC_LEN_W;

  logic                compressed_mode;
  logic                delta_mode;
  logic [SW-1:0]       source_length;
  logic [LW-1:0]       dest_size;

  zrd_pkg::state_t     state;
  zrd_pkg::state_t     state_next;
  zrd_pkg::phase_t     phase;
  zrd_pkg::phase_t     phase_next;
  logic [LW-1:0]       wp;
  logic [LW-1:0]       wp_next;
  logic [SW-1:0]       consumed;
  logic [7:0]          litrem;
  logic [7:0]          litrem_next;
  logic                err;
  logic                err_next;

  logic [AW-1:0]       op_addr;
  logic [7:0]          op_byte;
  logic                op_ok;
  logic [7:0]          zcnt;

  logic                in_acc;
  logic [7:0]          b;
  logic                addr_ok;
  logic [LW-1:0]       lim;
  logic [SW-1:0]       srclen;
  logic [SW-1:0]       cons_inc;
  logic                frame_end;
  logic                active;
  logic                do_put;
  logic                do_zero;
  logic [LW-1:0]       room;
  logic [7:0]          run_len;

  assign in_acc  = in_valid && !in_stall;
  assign b       = in_data.byte_value;
  assign addr_ok = 32'(in_data.mem_address) < zrd_pkg::DEST_DEPTH;

  // frame decode of one source word
  always_comb begin
    lim       = (32'(dest_size) > zrd_pkg::DEST_DEPTH) ? LW'(zrd_pkg::DEST_DEPTH) : dest_size;
    srclen    = (source_length == '0) ? SW'(1) : source_length;
    cons_inc  = consumed + SW'(1);
    frame_end = (cons_inc >= source_length) || (cons_inc == '0);
    active    = (wp < lim) && !err;
    room      = lim - wp;
    run_len   = (LW'(b) > room) ? room[7:0] : b;
    do_put      = 1'b0;
    do_zero     = 1'b0;
    wp_next     = wp;
    phase_next  = phase;
    litrem_next = litrem;
    err_next    = err;
    if (active) begin
      if (!compressed_mode) begin
        do_put = 1'b1;
      end else begin
        case (phase)
          zrd_pkg::PH_LITERALS: begin
            do_put      = 1'b1;
            litrem_next = litrem - 8'd1;
            if (litrem == 8'd1) begin
              phase_next = zrd_pkg::PH_ZERO_COUNT;
            end
          end
          zrd_pkg::PH_ZERO_COUNT: begin
            wp_next    = wp + LW'(run_len);
            phase_next = zrd_pkg::PH_LIT_COUNT;
            do_zero    = !delta_mode && (run_len != 8'd0);
          end
          default: begin
            phase_next = zrd_pkg::PH_LIT_COUNT;
            if (({1'b0, consumed} + 17'd1 + 17'(b)) > {1'b0, srclen}) begin
              err_next = 1'b1;
            end else if (b == 8'd0) begin
              phase_next = zrd_pkg::PH_ZERO_COUNT;
            end else begin
              litrem_next = b;
              phase_next  = zrd_pkg::PH_LITERALS;
            end
          end
        endcase
      end
    end
    if (do_put) begin
      wp_next = wp + LW'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      zrd_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            zrd_pkg::FUNC_SOURCE: begin
              if (do_put && delta_mode) begin
                state_next = zrd_pkg::ST_RMW;
              end else if (do_zero) begin
                state_next = zrd_pkg::ST_ZERO;
              end
            end
            zrd_pkg::FUNC_READ: state_next = zrd_pkg::ST_RDATA;
            default: state_next = zrd_pkg::ST_IDLE;
          endcase
        end
      end
      zrd_pkg::ST_ZERO: begin
        if (zcnt == 8'd1) begin
          state_next = zrd_pkg::ST_IDLE;
        end
      end
      default: state_next = zrd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ram_req  = '0;
    in_stall = (state != zrd_pkg::ST_IDLE) || pend_valid;
    case (state)
      zrd_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            zrd_pkg::FUNC_SOURCE: begin
              ram_req.addr  = AW'(wp);
              ram_req.wdata = b;
              ram_req.we    = do_put && !delta_mode;
              ram_req.re    = do_put && delta_mode;
            end
            zrd_pkg::FUNC_PRELOAD: begin
              ram_req.addr  = AW'(in_data.mem_address);
              ram_req.wdata = b;
              ram_req.we    = addr_ok;
            end
            zrd_pkg::FUNC_READ: begin
              ram_req.addr = AW'(in_data.mem_address);
              ram_req.re   = 1'b1;
            end
            default: ram_req = '0;
          endcase
        end
      end
      zrd_pkg::ST_RMW: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = op_addr;
        ram_req.wdata = ram_rdata + op_byte;
      end
      zrd_pkg::ST_ZERO: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = op_addr;
        ram_req.wdata = 8'd0;
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_mode <= 1'b1;
      delta_mode      <= 1'b0;
      source_length   <= SW'(1);
      dest_size       <= LW'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        zrd_pkg::CFG_COMPRESSED: compressed_mode <= cfg_data[0];
        zrd_pkg::CFG_DELTA:      delta_mode      <= cfg_data[0];
        zrd_pkg::CFG_SRC_LEN:    source_length   <= cfg_data[SW-1:0];
        zrd_pkg::CFG_DEST_SIZE:  dest_size       <= cfg_data[LW-1:0];
        default:                 dest_size       <= dest_size;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= zrd_pkg::ST_IDLE;
      wp         <= '0;
      consumed   <= '0;
      phase      <= zrd_pkg::PH_LIT_COUNT;
      litrem     <= '0;
      err        <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pend_take) begin
        pend_valid <= 1'b0;
      end
      if (in_acc && (in_data.func == zrd_pkg::FUNC_SOURCE)) begin
        if (frame_end) begin
          wp         <= '0;
          consumed   <= '0;
          phase      <= zrd_pkg::PH_LIT_COUNT;
          litrem     <= '0;
          err        <= 1'b0;
          pend_valid <= 1'b1;
        end else begin
          wp       <= wp_next;
          consumed <= cons_inc;
          phase    <= phase_next;
          litrem   <= litrem_next;
          err      <= err_next;
        end
      end
      if (state == zrd_pkg::ST_RDATA) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // operand and result holding, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_byte <= b;
      op_ok   <= addr_ok;
      op_addr <= AW'(wp);
      zcnt    <= run_len;
      if ((in_data.func == zrd_pkg::FUNC_SOURCE) && frame_end) begin
        pend.result_kind <= zrd_pkg::RESULT_REPORT;
        pend.read_data   <= 8'd0;
        pend.out_length  <= wp_next;
        pend.frame_error <= err_next;
      end
    end else if (state == zrd_pkg::ST_ZERO) begin
      op_addr <= op_addr + AW'(1);
      zcnt    <= zcnt - 8'd1;
    end
    if (state == zrd_pkg::ST_RDATA) begin
      pend.result_kind <= zrd_pkg::RESULT_READ;
      pend.read_data   <= op_ok ? ram_rdata : 8'd0;
      pend.out_length  <= '0;
      pend.frame_error <= 1'b0;
    end
  end

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    state == zrd_pkg::ST_ZERO |-> zcnt != 8'd0)
    else $error("zero run entered with empty count");

  a_read_before_use: assert property (@(posedge clk) disable iff (rst)
    (state == zrd_pkg::ST_RMW || state == zrd_pkg::ST_RDATA) |-> $past(ram_req.re))
    else $error("memory data used without a read issued");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("read and write in the same cycle");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    32'(wp) <= zrd_pkg::DEST_DEPTH)
    else $error("write pointer beyond memory");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !pend_take |=> pend_valid && $stable(pend))
    else $error("held result changed before hand-off");

endmodule

FILE: rtl/core/zero_run_delta_decompressor_unit.sv
// zero_run_delta_decompressor_unit: top level, output register stage
// uses zrd_pkg, zrd_ctrl and zrd_ram
//
//   channel  dir  handshake          payload
//   cfg      in   cfg_we             cfg_index, cfg_data
//   in       in   in_valid/in_stall  in_data  (func, byte_value, mem_address)
//   out      out  out_valid/out_stall out_data (result_kind, read_data, out_length,
//                                               frame_error)
//
// preload, plain store and count words are done as they are taken; a delta add reads then
// writes on the single memory port; a plain zero run of n bytes then writes n zero bytes
// a read and the last word of a frame pass their result through a holding register into the
// output register before the next word is taken
// reset is synchronous; the memory contents are not cleared
// a stalled output holds its word while the next item is still accepted
module zero_run_delta_decompressor_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [zrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zrd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  zrd_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output zrd_pkg::out_word_t            out_data
);

  zrd_pkg::ram_req_t  ram_req;
  logic [7:0]         ram_rdata;
  zrd_pkg::out_word_t pend;
  logic               pend_valid;
  logic               pend_take;

  zrd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .pend       (pend),
    .pend_valid (pend_valid),
    .pend_take  (pend_take)
  );

  zrd_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign pend_take = pend_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      out_data <= pend;
    end
  end

endmodule
